@@ hw/rtl/viewport_zoom_pan_mapper_assert.svh @@
// ----------------------------------------------------------------------------
// Viewport mapper assertion macros
// Clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIEWPORT_ZOOM_PAN_MAPPER_ASSERT_SVH
`define VIEWPORT_ZOOM_PAN_MAPPER_ASSERT_SVH

// same-cycle implication
`define VZPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VZPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vzpm_pkg.sv @@
// ----------------------------------------------------------------------------
// vzpm_pkg
// Shared widths, command codes and fixed constants of the viewport mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vzpm_pkg;

    // word field widths
    localparam int FUNC_W  = 4;
    localparam int PT_W    = 12;
    localparam int SHIFT_W = 12;
    localparam int CANV_W  = 15;
    localparam int ZOOM_W  = 16;

    // configuration
    localparam int SCR_W   = 12;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int SCR_W_RST = 640;
    localparam int SCR_H_RST = 480;
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // zoom in Q2.14
    localparam int ZOOM_FRAC = 14;
    localparam logic [ZOOM_W-1:0] ZOOM_ONE  = 16'd16384;
    localparam logic [ZOOM_W-1:0] ZOOM_MAX  = 16'd49152;
    localparam logic [ZOOM_W-1:0] ZOOM_STEP = 16'd492;

    // pan step is visible / 25
    localparam int PAN_DIV = 25;
    localparam int R25_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_ZOOM_IN  = 4'd0,
        FN_ZOOM_OUT = 4'd1,
        FN_RIGHT    = 4'd2,
        FN_LEFT     = 4'd3,
        FN_UP       = 4'd4,
        FN_DOWN     = 4'd5,
        FN_HOME     = 4'd6,
        FN_CLAMP    = 4'd7,
        FN_MAP      = 4'd8
    } t_func;

endpackage

@@ hw/rtl/vzpm_in_if.sv @@
// ----------------------------------------------------------------------------
// vzpm_in_if
// Command channel: valid/ready with func and screen point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vzpm_in_if
    import vzpm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PT_W-1:0]   point_x;
    logic [PT_W-1:0]   point_y;

    modport source (output valid, output func, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input func, input point_x, input point_y,
                    output ready);
endinterface

@@ hw/rtl/vzpm_out_if.sv @@
// ----------------------------------------------------------------------------
// vzpm_out_if
// Result channel: valid/ready with shift, canvas point, centre and zoom.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vzpm_out_if
    import vzpm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [SHIFT_W-1:0]        shift_x;
    logic [SHIFT_W-1:0]        shift_y;
    logic signed [CANV_W-1:0]  canvas_x;
    logic signed [CANV_W-1:0]  canvas_y;
    logic signed [CANV_W-1:0]  centre_x;
    logic signed [CANV_W-1:0]  centre_y;
    logic [ZOOM_W-1:0]         zoom_now;

    modport source (output valid, output shift_x, output shift_y, output canvas_x,
                    output canvas_y, output centre_x, output centre_y, output zoom_now,
                    input ready);
    modport sink   (input valid, input shift_x, input shift_y, input canvas_x,
                    input canvas_y, input centre_x, input centre_y, input zoom_now,
                    output ready);
endinterface

@@ hw/rtl/viewport_zoom_pan_mapper.sv @@
// ----------------------------------------------------------------------------
// viewport_zoom_pan_mapper
// Zoom/pan viewport state with a bit-serial divider for visible size and map.
// ----------------------------------------------------------------------------
// Use:
//   i_cmd carries one command word (func, point_x, point_y); o_res returns
//   exactly one result word per command. Both are valid/ready, a word moves
//   on a clock edge with valid and ready high.
//   The APB port holds screen_width (0x0) and screen_height (0x4); writes land
//   in the access cycle, pready is tied high. Write only while idle.
// Command path (states from accept to result loaded):
//   pan, no-op       : S_EXEC, S_FIN
//   clamp            : S_EXEC, S_CLAMP, S_FIN
//   zoom, home       : S_EXEC, S_DIV, S_FIN (a zoom at its limit skips S_DIV)
//   map              : S_EXEC, S_DIV, S_MAP, S_FIN
//   S_DIV runs the restoring divider, one quotient bit per cycle;
//   the divide by 25 for the pan step rides on the same bits.
//   One command is in flight at a time; i_cmd.ready is high only when idle.
// Reset (synchronous, i_rst_n low): screen 640 x 480, zoom 1.0, centre at
//   half screen, visible size and pan steps for zoom 1.0, no result pending.
// Stall: the result register holds its word until o_res.ready; a new command
//   can be taken meanwhile and waits at the end of its work for the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "viewport_zoom_pan_mapper_assert.svh"

module viewport_zoom_pan_mapper
    import vzpm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vzpm_in_if.sink            i_cmd,
    vzpm_out_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // derived widths
    // ------------------------------------------------------------------
    localparam int QW      = SCR_W + FRAC_BITS;          // visible size, quotient
    localparam int PW      = QW - 4;                     // pan step (< 2^QW / 25)
    localparam int CI_BITS = (COORD_BITS > SCR_W - 1) ? COORD_BITS : SCR_W - 1;
    localparam int CW      = CI_BITS + FRAC_BITS + 3;    // signed centre
    localparam int MW      = CW + 2;                     // working sums
    localparam int CNTW    = $clog2(QW);
    localparam int DIV_PRE = ZOOM_FRAC + FRAC_BITS - QW; // numerator bits above quotient

    localparam longint CEN_MAX_L = (longint'(1) << (COORD_BITS + FRAC_BITS + 2)) - 1;
    localparam longint OUT_MAX_L = (longint'(1) << (COORD_BITS + 2)) - 1;
    localparam longint CMASK_L   = (longint'(1) << COORD_BITS) - 1;

    localparam logic signed [MW-1:0] K_CEN_MAX = MW'(CEN_MAX_L);
    localparam logic signed [MW-1:0] K_CEN_MIN = MW'(-CEN_MAX_L - 1);
    localparam logic signed [MW-1:0] K_OUT_MAX = MW'(OUT_MAX_L);
    localparam logic signed [MW-1:0] K_OUT_MIN = MW'(-OUT_MAX_L - 1);
    localparam logic signed [MW-1:0] K_CMASK   = MW'(CMASK_L);
    localparam logic [PT_W-1:0]      PT_MASK   = PT_W'(CMASK_L);

    localparam logic [QW-1:0] VIS_W_RST = QW'(SCR_W_RST * (2 ** FRAC_BITS));
    localparam logic [QW-1:0] VIS_H_RST = QW'(SCR_H_RST * (2 ** FRAC_BITS));
    localparam logic [PW-1:0] PAN_X_RST = PW'(SCR_W_RST * (2 ** FRAC_BITS) / PAN_DIV);
    localparam logic [PW-1:0] PAN_Y_RST = PW'(SCR_H_RST * (2 ** FRAC_BITS) / PAN_DIV);
    localparam logic signed [CW-1:0] CEN_X_RST = CW'((SCR_W_RST / 2) * (2 ** FRAC_BITS));
    localparam logic signed [CW-1:0] CEN_Y_RST = CW'((SCR_H_RST / 2) * (2 ** FRAC_BITS));

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_DIV   = 6'b000100,
        S_CLAMP = 6'b001000,
        S_MAP   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    // truncate Q.F toward zero
    function automatic logic signed [MW-1:0] trunc0(input logic signed [MW-1:0] q);
        if (q[MW-1]) begin
            trunc0 = -((-q) >>> FRAC_BITS);
        end else begin
            trunc0 = q >>> FRAC_BITS;
        end
    endfunction

    function automatic logic signed [MW-1:0] sat_mw(input logic signed [MW-1:0] v,
                                                   input logic signed [MW-1:0] lo,
                                                   input logic signed [MW-1:0] hi);
        if (v < lo) begin
            sat_mw = lo;
        end else if (v > hi) begin
            sat_mw = hi;
        end else begin
            sat_mw = v;
        end
    endfunction

    // truncate, saturate to the output range, keep the low 15 bits
    function automatic logic [CANV_W-1:0] enc_out(input logic signed [MW-1:0] q);
        logic signed [MW-1:0] v;
        v = sat_mw(trunc0(q), K_OUT_MIN, K_OUT_MAX);
        enc_out = v[CANV_W-1:0];
    endfunction

    function automatic logic signed [CW-1:0] clamp_cen(input logic signed [MW-1:0] s,
                                                      input logic signed [MW-1:0] b,
                                                      input logic signed [MW-1:0] half,
                                                      input logic signed [MW-1:0] cen);
        logic signed [MW-1:0] c;
        if (s[MW-1]) begin
            c = half;
        end else if (s > b) begin
            c = (b <<< FRAC_BITS) + half;
        end else begin
            c = cen;
        end
        c = sat_mw(c, K_CEN_MIN, K_CEN_MAX);
        clamp_cen = c[CW-1:0];
    endfunction

    function automatic logic [SHIFT_W-1:0] clamp_shift(input logic signed [MW-1:0] s,
                                                       input logic signed [MW-1:0] b);
        logic signed [MW-1:0] v;
        if (s[MW-1]) begin
            v = '0;
        end else if (s > b) begin
            v = b;
        end else begin
            v = s;
        end
        v = sat_mw(v, '0, K_CMASK);
        clamp_shift = v[SHIFT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    logic [SCR_W-1:0]        r_scr_w, n_scr_w, r_scr_h, n_scr_h;
    logic [ZOOM_W-1:0]       r_zoom, n_zoom;
    logic signed [CW-1:0]    r_cen_x, n_cen_x, r_cen_y, n_cen_y;
    logic [QW-1:0]           r_vis_w, n_vis_w, r_vis_h, n_vis_h;
    logic [PW-1:0]           r_pan_x, n_pan_x, r_pan_y, n_pan_y;

    logic [FUNC_W-1:0]       r_func, n_func;
    logic [PT_W-1:0]         r_px, n_px, r_py, n_py;
    logic [ZOOM_W-1:0]       r_rem_w, n_rem_w, r_rem_h, n_rem_h;
    logic [QW-1:0]           r_quo_w, n_quo_w, r_quo_h, n_quo_h;
    logic [R25_W-1:0]        r_r25_w, n_r25_w, r_r25_h, n_r25_h;
    logic [PW-1:0]           r_p25_w, n_p25_w, r_p25_h, n_p25_h;
    logic [CNTW-1:0]         r_cnt, n_cnt;
    logic signed [MW-1:0]    r_s_x, n_s_x, r_s_y, n_s_y;
    logic signed [MW-1:0]    r_b_x, n_b_x, r_b_y, n_b_y;
    logic signed [MW-1:0]    r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [SHIFT_W-1:0]      r_shx, n_shx, r_shy, n_shy;

    logic [SHIFT_W-1:0]      r_o_shx, n_o_shx, r_o_shy, n_o_shy;
    logic [CANV_W-1:0]       r_o_canx, n_o_canx, r_o_cany, n_o_cany;
    logic [CANV_W-1:0]       r_o_cenx, n_o_cenx, r_o_ceny, n_o_ceny;
    logic [ZOOM_W-1:0]       r_o_zoom, n_o_zoom;

    // ------------------------------------------------------------------
    // datapath terms
    // ------------------------------------------------------------------
    logic                    apb_wr;
    logic                    is_map;
    logic [SCR_W-1:0]        numer_w, numer_h;
    logic [ZOOM_W:0]         t_w, t_h;
    logic                    ge_w, ge_h;
    logic [ZOOM_W-1:0]       rem_nx_w, rem_nx_h;
    logic [QW-1:0]           quo_nx_w, quo_nx_h;
    logic [R25_W:0]          t25_w, t25_h;
    logic                    ge25_w, ge25_h;
    logic [R25_W-1:0]        r25_nx_w, r25_nx_h;
    logic [PW-1:0]           p25_nx_w, p25_nx_h;
    logic signed [MW-1:0]    cen_ext_x, cen_ext_y, half_x, half_y;
    logic signed [MW-1:0]    pan_ext_x, pan_ext_y, quo_ext_w, quo_ext_h;
    logic signed [MW-1:0]    scr_q_w, scr_q_h, vis_ext_w, vis_ext_h;
    logic signed [MW-1:0]    pan_r, pan_l, pan_u, pan_d;

    assign apb_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_HEIGHT) ? PDATA_W'(r_scr_h) : PDATA_W'(r_scr_w);

    assign is_map  = (r_func == FN_MAP);
    assign numer_w = is_map ? (r_px & PT_MASK) : r_scr_w;
    assign numer_h = is_map ? (r_py & PT_MASK) : r_scr_h;

    // restoring divide by the zoom, one quotient bit a cycle, MSB first
    assign t_w      = {r_rem_w, 1'b0};
    assign t_h      = {r_rem_h, 1'b0};
    assign ge_w     = (t_w >= {1'b0, r_zoom});
    assign ge_h     = (t_h >= {1'b0, r_zoom});
    assign rem_nx_w = ge_w ? ZOOM_W'(t_w - {1'b0, r_zoom}) : t_w[ZOOM_W-1:0];
    assign rem_nx_h = ge_h ? ZOOM_W'(t_h - {1'b0, r_zoom}) : t_h[ZOOM_W-1:0];
    assign quo_nx_w = {r_quo_w[QW-2:0], ge_w};
    assign quo_nx_h = {r_quo_h[QW-2:0], ge_h};

    // divide by 25 fed with the quotient bits as they appear
    assign t25_w    = {r_r25_w, ge_w};
    assign t25_h    = {r_r25_h, ge_h};
    assign ge25_w   = (t25_w >= (R25_W + 1)'(PAN_DIV));
    assign ge25_h   = (t25_h >= (R25_W + 1)'(PAN_DIV));
    assign r25_nx_w = ge25_w ? R25_W'(t25_w - (R25_W + 1)'(PAN_DIV)) : t25_w[R25_W-1:0];
    assign r25_nx_h = ge25_h ? R25_W'(t25_h - (R25_W + 1)'(PAN_DIV)) : t25_h[R25_W-1:0];
    assign p25_nx_w = {r_p25_w[PW-2:0], ge25_w};
    assign p25_nx_h = {r_p25_h[PW-2:0], ge25_h};

    assign cen_ext_x = MW'(r_cen_x);
    assign cen_ext_y = MW'(r_cen_y);
    assign half_x    = MW'({1'b0, r_vis_w[QW-1:1]});
    assign half_y    = MW'({1'b0, r_vis_h[QW-1:1]});
    assign pan_ext_x = MW'({1'b0, r_pan_x});
    assign pan_ext_y = MW'({1'b0, r_pan_y});
    assign quo_ext_w = MW'({1'b0, r_quo_w});
    assign quo_ext_h = MW'({1'b0, r_quo_h});
    assign scr_q_w   = MW'({1'b0, r_scr_w, {FRAC_BITS{1'b0}}});
    assign scr_q_h   = MW'({1'b0, r_scr_h, {FRAC_BITS{1'b0}}});
    assign vis_ext_w = MW'({1'b0, r_vis_w});
    assign vis_ext_h = MW'({1'b0, r_vis_h});

    assign pan_r = sat_mw(cen_ext_x + pan_ext_x, K_CEN_MIN, K_CEN_MAX);
    assign pan_l = sat_mw(cen_ext_x - pan_ext_x, K_CEN_MIN, K_CEN_MAX);
    assign pan_u = sat_mw(cen_ext_y - pan_ext_y, K_CEN_MIN, K_CEN_MAX);
    assign pan_d = sat_mw(cen_ext_y + pan_ext_y, K_CEN_MIN, K_CEN_MAX);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_scr_w     = r_scr_w;
        n_scr_h     = r_scr_h;
        n_zoom      = r_zoom;
        n_cen_x     = r_cen_x;
        n_cen_y     = r_cen_y;
        n_vis_w     = r_vis_w;
        n_vis_h     = r_vis_h;
        n_pan_x     = r_pan_x;
        n_pan_y     = r_pan_y;
        n_func      = r_func;
        n_px        = r_px;
        n_py        = r_py;
        n_rem_w     = r_rem_w;
        n_rem_h     = r_rem_h;
        n_quo_w     = r_quo_w;
        n_quo_h     = r_quo_h;
        n_r25_w     = r_r25_w;
        n_r25_h     = r_r25_h;
        n_p25_w     = r_p25_w;
        n_p25_h     = r_p25_h;
        n_cnt       = r_cnt;
        n_s_x       = r_s_x;
        n_s_y       = r_s_y;
        n_b_x       = r_b_x;
        n_b_y       = r_b_y;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_shx       = r_shx;
        n_shy       = r_shy;
        n_o_shx     = r_o_shx;
        n_o_shy     = r_o_shy;
        n_o_canx    = r_o_canx;
        n_o_cany    = r_o_cany;
        n_o_cenx    = r_o_cenx;
        n_o_ceny    = r_o_ceny;
        n_o_zoom    = r_o_zoom;

        if (apb_wr) begin
            case (paddr[2])
                CFG_IDX_WIDTH:  n_scr_w = pwdata[SCR_W-1:0];
                CFG_IDX_HEIGHT: n_scr_h = pwdata[SCR_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_func  = i_cmd.func;
                    n_px    = i_cmd.point_x;
                    n_py    = i_cmd.point_y;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_FIN;
                // divider preload, only used when S_DIV follows
                n_rem_w = ZOOM_W'({numer_w, {DIV_PRE{1'b0}}});
                n_rem_h = ZOOM_W'({numer_h, {DIV_PRE{1'b0}}});
                n_r25_w = '0;
                n_r25_h = '0;
                n_cnt   = CNTW'(QW - 1);
                case (t_func'(r_func))
                    FN_ZOOM_IN: begin
                        if (r_zoom < ZOOM_MAX) begin
                            n_zoom  = r_zoom + ZOOM_STEP;
                            n_state = S_DIV;
                        end
                    end
                    FN_ZOOM_OUT: begin
                        if (r_zoom > ZOOM_ONE) begin
                            n_zoom  = ((r_zoom - ZOOM_STEP) < ZOOM_ONE) ? ZOOM_ONE
                                                                       : r_zoom - ZOOM_STEP;
                            n_state = S_DIV;
                        end
                    end
                    FN_RIGHT: n_cen_x = pan_r[CW-1:0];
                    FN_LEFT:  n_cen_x = pan_l[CW-1:0];
                    FN_UP:    n_cen_y = pan_u[CW-1:0];
                    FN_DOWN:  n_cen_y = pan_d[CW-1:0];
                    FN_HOME: begin
                        n_zoom  = ZOOM_ONE;
                        n_cen_x = CW'({1'b0, r_scr_w[SCR_W-1:1], {FRAC_BITS{1'b0}}});
                        n_cen_y = CW'({1'b0, r_scr_h[SCR_W-1:1], {FRAC_BITS{1'b0}}});
                        n_state = S_DIV;
                    end
                    FN_CLAMP: begin
                        n_s_x   = trunc0(cen_ext_x - half_x);
                        n_s_y   = trunc0(cen_ext_y - half_y);
                        n_b_x   = trunc0(scr_q_w - vis_ext_w);
                        n_b_y   = trunc0(scr_q_h - vis_ext_h);
                        n_state = S_CLAMP;
                    end
                    FN_MAP: n_state = S_DIV;
                    default: ;
                endcase
            end

            S_DIV: begin
                n_rem_w = rem_nx_w;
                n_rem_h = rem_nx_h;
                n_quo_w = quo_nx_w;
                n_quo_h = quo_nx_h;
                n_r25_w = r25_nx_w;
                n_r25_h = r25_nx_h;
                n_p25_w = p25_nx_w;
                n_p25_h = p25_nx_h;
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (is_map) begin
                        n_state = S_MAP;
                    end else begin
                        n_vis_w = quo_nx_w;
                        n_vis_h = quo_nx_h;
                        n_pan_x = p25_nx_w;
                        n_pan_y = p25_nx_h;
                        n_state = S_FIN;
                    end
                end
            end

            S_CLAMP: begin
                n_cen_x = clamp_cen(r_s_x, r_b_x, half_x, cen_ext_x);
                n_cen_y = clamp_cen(r_s_y, r_b_y, half_y, cen_ext_y);
                n_shx   = clamp_shift(r_s_x, r_b_x);
                n_shy   = clamp_shift(r_s_y, r_b_y);
                n_state = S_FIN;
            end

            S_MAP: begin
                n_sum_x = cen_ext_x - half_x + quo_ext_w;
                n_sum_y = cen_ext_y - half_y + quo_ext_h;
                n_state = S_FIN;
            end

            S_FIN: begin
                // wait for the result register to drain
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_o_shx     = (r_func == FN_CLAMP) ? r_shx : '0;
                    n_o_shy     = (r_func == FN_CLAMP) ? r_shy : '0;
                    n_o_canx    = is_map ? enc_out(r_sum_x) : '0;
                    n_o_cany    = is_map ? enc_out(r_sum_y) : '0;
                    n_o_cenx    = enc_out(cen_ext_x);
                    n_o_ceny    = enc_out(cen_ext_y);
                    n_o_zoom    = r_zoom;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_scr_w     <= SCR_W'(SCR_W_RST);
            r_scr_h     <= SCR_W'(SCR_H_RST);
            r_zoom      <= ZOOM_ONE;
            r_cen_x     <= CEN_X_RST;
            r_cen_y     <= CEN_Y_RST;
            r_vis_w     <= VIS_W_RST;
            r_vis_h     <= VIS_H_RST;
            r_pan_x     <= PAN_X_RST;
            r_pan_y     <= PAN_Y_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_scr_w     <= n_scr_w;
            r_scr_h     <= n_scr_h;
            r_zoom      <= n_zoom;
            r_cen_x     <= n_cen_x;
            r_cen_y     <= n_cen_y;
            r_vis_w     <= n_vis_w;
            r_vis_h     <= n_vis_h;
            r_pan_x     <= n_pan_x;
            r_pan_y     <= n_pan_y;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_px     <= n_px;
        r_py     <= n_py;
        r_rem_w  <= n_rem_w;
        r_rem_h  <= n_rem_h;
        r_quo_w  <= n_quo_w;
        r_quo_h  <= n_quo_h;
        r_r25_w  <= n_r25_w;
        r_r25_h  <= n_r25_h;
        r_p25_w  <= n_p25_w;
        r_p25_h  <= n_p25_h;
        r_cnt    <= n_cnt;
        r_s_x    <= n_s_x;
        r_s_y    <= n_s_y;
        r_b_x    <= n_b_x;
        r_b_y    <= n_b_y;
        r_sum_x  <= n_sum_x;
        r_sum_y  <= n_sum_y;
        r_shx    <= n_shx;
        r_shy    <= n_shy;
        r_o_shx  <= n_o_shx;
        r_o_shy  <= n_o_shy;
        r_o_canx <= n_o_canx;
        r_o_cany <= n_o_cany;
        r_o_cenx <= n_o_cenx;
        r_o_ceny <= n_o_ceny;
        r_o_zoom <= n_o_zoom;
    end

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.shift_x  = r_o_shx;
    assign o_res.shift_y  = r_o_shy;
    assign o_res.canvas_x = r_o_canx;
    assign o_res.canvas_y = r_o_cany;
    assign o_res.centre_x = r_o_cenx;
    assign o_res.centre_y = r_o_ceny;
    assign o_res.zoom_now = r_o_zoom;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `VZPM_ASSERT_SAME(a_zoom_range, 1'b1, (r_zoom >= ZOOM_ONE) && (r_zoom < ZOOM_MAX + ZOOM_STEP), "zoom left its range")
    `VZPM_ASSERT_SAME(a_rem_below_zoom, r_state == S_DIV, (r_rem_w < r_zoom) && (r_rem_h < r_zoom), "divider remainder not below zoom")
    `VZPM_ASSERT_SAME(a_r25_range, r_state == S_DIV, (r_r25_w < R25_W'(PAN_DIV)) && (r_r25_h < R25_W'(PAN_DIV)), "pan divider remainder out of range")
    `VZPM_ASSERT_NEXT(a_fin_loads, (r_state == S_FIN) && (!r_out_valid || o_res.ready), r_out_valid && (r_state == S_IDLE), "result word not loaded")

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for viewport_zoom_pan_mapper. Command words go in on
// i_cmd under random gaps, result words come back on o_res under random
// back-pressure, and each one is compared field by field with the bench's own
// prediction of zoom, pan, home, clamp and map. The screen size registers are
// rewritten between phases through the APB port and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import vzpm_pkg::*;

    // block parameters at their defaults
    localparam int     FRAC     = 8;
    localparam int     COORD    = 12;
    localparam longint PX_ONE   = longint'(1) << FRAC;
    localparam longint CEN_HI   = (longint'(1) << (COORD + FRAC + 2)) - 1;
    localparam longint CEN_LO   = -(longint'(1) << (COORD + FRAC + 2));
    localparam longint OUT_HI   = (longint'(1) << (COORD + 2)) - 1;
    localparam longint OUT_LO   = -(longint'(1) << (COORD + 2));
    localparam longint SHIFT_HI = (longint'(1) << SHIFT_W) - 1;

    // idle odds in percent, and how long nothing may move before giving up
    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 275;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PT_W-1:0]   px;
        logic [PT_W-1:0]   py;
    } cmd_word_t;

    typedef struct {
        logic [SHIFT_W-1:0]       shift_x;
        logic [SHIFT_W-1:0]       shift_y;
        logic signed [CANV_W-1:0] canvas_x;
        logic signed [CANV_W-1:0] canvas_y;
        logic signed [CANV_W-1:0] centre_x;
        logic signed [CANV_W-1:0] centre_y;
        logic [ZOOM_W-1:0]        zoom_now;
    } result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    vzpm_in_if  cmd_if ();
    vzpm_out_if res_if ();

    viewport_zoom_pan_mapper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    cmd_word_t cmd_backlog[$];   // words waiting to be offered
    result_t   due_results[$];   // predictions waiting for their word
    logic      cmd_fired;        // i_cmd word taken at the last rising edge
    logic      hold_cmd;         // sender paused
    logic      calm;             // no idling on either side
    int        mismatches;
    int        results_seen;
    int        stall_count;

    // shadow of the viewport: registers, zoom and Q14.8 / Q12.8 geometry
    logic [SCR_W-1:0]  scr_w;
    logic [SCR_W-1:0]  scr_h;
    logic [ZOOM_W-1:0] zoom_q;
    longint            cen_x, cen_y;
    longint            vis_w, vis_h;
    longint            step_x, step_y;

    // ------------------------------------------------------------------------
    // Viewport shadow
    // ------------------------------------------------------------------------
    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // drop the fraction, rounding toward zero
    function automatic longint trunc_px(longint q);
        return (q >= 0) ? (q >>> FRAC) : -((-q) >>> FRAC);
    endfunction

    // visible size = screen / zoom, pan step = 4% of it
    function automatic void refresh_sizes();
        vis_w  = (longint'(scr_w) << (ZOOM_FRAC + FRAC)) / longint'(zoom_q);
        vis_h  = (longint'(scr_h) << (ZOOM_FRAC + FRAC)) / longint'(zoom_q);
        step_x = vis_w / PAN_DIV;
        step_y = vis_h / PAN_DIV;
    endfunction

    function automatic void go_home();
        zoom_q = ZOOM_ONE;
        cen_x  = longint'(scr_w >> 1) << FRAC;
        cen_y  = longint'(scr_h >> 1) << FRAC;
        refresh_sizes();
    endfunction

    // pull one axis of the view back onto the canvas, give the source shift
    function automatic longint fit_axis(logic [SCR_W-1:0] scr, longint vis,
                                        inout longint cen);
        longint half, s, border;
        half   = vis >>> 1;
        s      = trunc_px(cen - half);
        border = trunc_px((longint'(scr) << FRAC) - vis);
        if (s < 0) begin
            cen = half;
            s   = 0;
        end else if (s > border) begin
            // border goes negative only after the screen was shrunk
            cen = border * PX_ONE + half;
            s   = border;
        end
        cen = clip(cen, CEN_LO, CEN_HI);
        return clip(s, 0, SHIFT_HI);
    endfunction

    function automatic longint project_axis(logic [PT_W-1:0] p, longint cen, longint vis);
        longint off;
        off = (longint'(p) << (ZOOM_FRAC + FRAC)) / longint'(zoom_q);
        return clip(trunc_px(cen - (vis >>> 1) + off), OUT_LO, OUT_HI);
    endfunction

    // one command through the shadow; returns the word the block must give
    function automatic result_t viewport_step(cmd_word_t w);
        result_t r;
        longint  sx, sy, cx, cy;
        sx = 0;
        sy = 0;
        cx = 0;
        cy = 0;
        case (w.func)
            FN_ZOOM_IN: begin
                if (zoom_q < ZOOM_MAX) begin
                    zoom_q = zoom_q + ZOOM_STEP;
                    refresh_sizes();
                end
            end
            FN_ZOOM_OUT: begin
                if (zoom_q > ZOOM_ONE) begin
                    zoom_q = (zoom_q - ZOOM_STEP < ZOOM_ONE) ? ZOOM_ONE : zoom_q - ZOOM_STEP;
                    refresh_sizes();
                end
            end
            FN_RIGHT: cen_x = clip(cen_x + step_x, CEN_LO, CEN_HI);
            FN_LEFT:  cen_x = clip(cen_x - step_x, CEN_LO, CEN_HI);
            FN_UP:    cen_y = clip(cen_y - step_y, CEN_LO, CEN_HI);
            FN_DOWN:  cen_y = clip(cen_y + step_y, CEN_LO, CEN_HI);
            FN_HOME:  go_home();
            FN_CLAMP: begin
                sx = fit_axis(scr_w, vis_w, cen_x);
                sy = fit_axis(scr_h, vis_h, cen_y);
            end
            FN_MAP: begin
                cx = project_axis(w.px, cen_x, vis_w);
                cy = project_axis(w.py, cen_y, vis_h);
            end
            default: ;  // spare codes: status only
        endcase
        r.shift_x  = sx[SHIFT_W-1:0];
        r.shift_y  = sy[SHIFT_W-1:0];
        r.canvas_x = cx[CANV_W-1:0];
        r.canvas_y = cy[CANV_W-1:0];
        r.centre_x = clip(trunc_px(cen_x), OUT_LO, OUT_HI);
        r.centre_y = clip(trunc_px(cen_y), OUT_LO, OUT_HI);
        r.zoom_now = zoom_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        // keep the log readable if the block is badly off; every one still counts
        if (mismatches < 200)
            $display("mismatch %s: got %0d want %0d (result word %0d)",
                     what, got, want, results_seen);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Command driver: offers words from the backlog at the falling edge. A word
    // stays up until taken; a fresh one follows only after the handshake.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_cmd
        cmd_word_t w;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_fired) begin
            if (cmd_backlog.size() != 0 && !hold_cmd &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                w = cmd_backlog.pop_front();
                cmd_if.valid   <= 1'b1;
                cmd_if.func    <= w.func;
                cmd_if.point_x <= w.px;
                cmd_if.point_y <= w.py;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin : drive_ready
        res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every taken command, checks every taken result.
    // The result check runs first so a prediction pushed on the same edge can
    // never be matched against a word that was already under way.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        result_t want;
        if (!i_rst_n) begin
            cmd_fired <= 1'b0;
        end else begin
            cmd_fired <= cmd_if.valid && cmd_if.ready;
            if (res_if.valid && res_if.ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = due_results.pop_front();
                    if (res_if.shift_x !== want.shift_x)
                        report_mismatch("shift_x", res_if.shift_x, want.shift_x);
                    if (res_if.shift_y !== want.shift_y)
                        report_mismatch("shift_y", res_if.shift_y, want.shift_y);
                    if (res_if.canvas_x !== want.canvas_x)
                        report_mismatch("canvas_x", res_if.canvas_x, want.canvas_x);
                    if (res_if.canvas_y !== want.canvas_y)
                        report_mismatch("canvas_y", res_if.canvas_y, want.canvas_y);
                    if (res_if.centre_x !== want.centre_x)
                        report_mismatch("centre_x", res_if.centre_x, want.centre_x);
                    if (res_if.centre_y !== want.centre_y)
                        report_mismatch("centre_y", res_if.centre_y, want.centre_y);
                    if (res_if.zoom_now !== want.zoom_now)
                        report_mismatch("zoom_now", res_if.zoom_now, want.zoom_now);
                end
                results_seen++;
            end
            if (cmd_if.valid && cmd_if.ready)
                due_results.push_back(viewport_step(
                    '{func: cmd_if.func, px: cmd_if.point_x, py: cmd_if.point_y}));
        end
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("[viewport_zoom_pan_mapper] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cmd(logic [FUNC_W-1:0] f, logic [PT_W-1:0] x, logic [PT_W-1:0] y);
        cmd_backlog.push_back('{func: f, px: x, py: y});
    endtask

    // mostly random points, with the corners now and then
    function automatic logic [PT_W-1:0] pick_point();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom_range((1 << PT_W) - 1);
    endfunction

    // Random traffic shaped to get somewhere: long zoom runs reach both zoom
    // limits, long pan runs drive the centre into saturation, then clamp and
    // map look at the result. Spare codes are noise and are not counted.
    task automatic queue_random(int count);
        int                left;
        int                pick;
        int                run;
        logic [FUNC_W-1:0] f;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                run = $urandom_range(70, 1);
                f   = ($urandom_range(1) == 1) ? FN_ZOOM_IN : FN_ZOOM_OUT;
                repeat (run) push_cmd(f, pick_point(), pick_point());
                left -= run;
            end else if (pick < 45) begin
                run = ($urandom_range(9) == 0) ? $urandom_range(140, 60) : $urandom_range(12, 1);
                f   = FN_RIGHT + $urandom_range(3);
                repeat (run) push_cmd(f, pick_point(), pick_point());
                left -= run;
            end else if (pick < 58) begin
                push_cmd(FN_CLAMP, pick_point(), pick_point());
                left--;
            end else if (pick < 78) begin
                push_cmd(FN_MAP, pick_point(), pick_point());
                left--;
            end else if (pick < 84) begin
                push_cmd(FN_HOME, pick_point(), pick_point());
                left--;
            end else if (pick < 94) begin
                push_cmd($urandom_range(FN_MAP), pick_point(), pick_point());
                left--;
            end else begin
                push_cmd($urandom_range((1 << FUNC_W) - 1, FN_MAP + 1),
                         pick_point(), pick_point());
            end
        end
    endtask

    // wait until every word is out and every result has come back
    task automatic drain();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || cmd_if.valid || due_results.size() != 0);
    endtask

    // write a screen register, read it back, then update the shadow copy
    task automatic cfg_write(logic idx, logic [SCR_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = PDATA_W'(val);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (prdata !== PDATA_W'(val))
            report_mismatch("prdata", prdata, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (idx == CFG_IDX_WIDTH)
            scr_w = val;
        else
            scr_h = val;
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial begin : run
        logic [SCR_W-1:0] w_px;
        logic [SCR_W-1:0] h_px;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.func    = '0;
        cmd_if.point_x = '0;
        cmd_if.point_y = '0;
        res_if.ready   = 1'b0;
        hold_cmd       = 1'b0;
        calm           = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        scr_w          = SCR_W_RST;
        scr_h          = SCR_H_RST;
        go_home();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, 640 x 480 after reset
        push_cmd(FN_MAP, '0, '0);                 // corners of the screen
        push_cmd(FN_MAP, '1, '1);
        push_cmd(FN_ZOOM_OUT, '0, '0);            // zoom out already at 1.0
        push_cmd(FN_ZOOM_IN, '1, '1);
        push_cmd(FN_MAP, 12'hAAA, 12'h555);
        push_cmd(FN_MAP, 12'h555, 12'hAAA);
        push_cmd(FN_RIGHT, '0, '0);
        push_cmd(FN_LEFT, '0, '0);
        push_cmd(FN_UP, '0, '0);
        push_cmd(FN_DOWN, '0, '0);
        push_cmd(FN_LEFT, '0, '0);
        push_cmd(FN_CLAMP, '0, '0);               // view hangs off the left edge
        push_cmd(FN_RIGHT, '0, '0);
        push_cmd(FN_RIGHT, '0, '0);
        push_cmd(FN_CLAMP, '1, '1);               // now past the right border
        push_cmd(FN_CLAMP, '0, '0);               // already inside
        push_cmd(FN_MAP, '1, '0);
        push_cmd(FN_HOME, '0, '0);
        push_cmd(FN_MAP + 1, '1, '1);             // spare codes
        push_cmd((1 << FUNC_W) - 1, '0, '0);
        push_cmd(FN_ZOOM_OUT, '0, '0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin w_px = 12'd1;    h_px = 12'd1;    end
                1:       begin w_px = 12'd4095; h_px = 12'd4095; end
                2:       begin w_px = 12'd4095; h_px = 12'd1;    end
                3:       begin w_px = 12'd1;    h_px = 12'd4095; end
                4:       begin w_px = SCR_W_RST; h_px = SCR_H_RST; end
                default: begin
                    w_px = $urandom_range(4095, 1);
                    h_px = $urandom_range(4095, 1);
                end
            endcase
            cfg_write(CFG_IDX_WIDTH, w_px);
            cfg_write(CFG_IDX_HEIGHT, h_px);

            if (ph == 0) begin
                // screen shrunk under a 640 x 480 view: border below zero
                push_cmd(FN_CLAMP, '0, '0);
                push_cmd(FN_MAP, '1, '1);
                push_cmd(FN_HOME, '0, '0);
                push_cmd(FN_ZOOM_IN, '0, '0);
                push_cmd(FN_CLAMP, '1, '1);
                push_cmd(FN_ZOOM_OUT, '1, '1);
            end

            // one phase runs with both sides flat out
            @(posedge i_clk);
            calm = (ph == 1);
            queue_random(PHASE_WORDS);

            if (ph == 2) begin
                // stop the sender half way and let the pipe run dry
                do @(posedge i_clk);
                while (cmd_backlog.size() > PHASE_WORDS / 2);
                hold_cmd = 1'b1;
                do @(posedge i_clk);
                while (cmd_if.valid || due_results.size() != 0);
                hold_cmd = 1'b0;
            end

            drain();
            calm = 1'b0;
        end

        // catch any stray word after the last one
        repeat (30) @(posedge i_clk);

        if (mismatches == 0)
            $display("[viewport_zoom_pan_mapper] OK");
        else
            $display("[viewport_zoom_pan_mapper] ERROR");
        $finish;
    end

endmodule
